/* hdl/tsgd_pkg.sv */
// Package for the touch swipe gesture decoder: event codes, direction codes,
// register map, reset values and the structs passed between the modules.
// No dependencies.
`default_nettype none

package tsgd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DirW   = 3;

  // event types and axis codes
  localparam logic [15:0] EVT_ABS = 16'd3;
  localparam logic [15:0] EVT_KEY = 16'd1;
  localparam logic [15:0] AXIS_X  = 16'd0;
  localparam logic [15:0] AXIS_Y  = 16'd1;

  // swipe direction codes
  localparam logic [DirW-1:0] DIR_NONE  = 3'd0;
  localparam logic [DirW-1:0] DIR_LEFT  = 3'd1;
  localparam logic [DirW-1:0] DIR_RIGHT = 3'd2;
  localparam logic [DirW-1:0] DIR_UP    = 3'd3;
  localparam logic [DirW-1:0] DIR_DOWN  = 3'd4;

  // register indexes (byte address = 4 * index)
  localparam int unsigned CfgAddrW = 5;
  localparam logic [2:0] REG_SCREEN_W = 3'd0;
  localparam logic [2:0] REG_SCREEN_H = 3'd1;
  localparam logic [2:0] REG_TOUCH_W  = 3'd2;
  localparam logic [2:0] REG_TOUCH_H  = 3'd3;
  localparam logic [2:0] REG_MIN_SW   = 3'd4;

  // register reset values
  localparam logic [15:0] RST_SCREEN_W = 16'd800;
  localparam logic [15:0] RST_SCREEN_H = 16'd480;
  localparam logic [15:0] RST_TOUCH_W  = 16'd1024;
  localparam logic [15:0] RST_TOUCH_H  = 16'd600;
  localparam logic [15:0] RST_MIN_SW   = 16'd20;

  // tracker update controls
  typedef struct packed {
    logic wr_x;
    logic wr_y;
    logic clr;
  } trk_ctl_t;

  // scaling unit status
  typedef struct packed {
    logic busy;
    logic done;
  } scl_stat_t;

endpackage

`default_nettype wire

/* hdl/tsgd_track.sv */
// Touch tracking registers: start and end coordinates of both axes.
// Depends on tsgd_pkg.
`default_nettype none

module tsgd_track (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tsgd_pkg::trk_ctl_t            ctl,
  input  wire logic [tsgd_pkg::CoordW-1:0]   val,
  output logic      [tsgd_pkg::CoordW-1:0]   start_x,
  output logic      [tsgd_pkg::CoordW-1:0]   start_y,
  output logic      [tsgd_pkg::CoordW-1:0]   end_x,
  output logic      [tsgd_pkg::CoordW-1:0]   end_y
);

  // the current position always equals the end position, so it is not kept twice
  logic [tsgd_pkg::CoordW-1:0] start_x_r, start_y_r, end_x_r, end_y_r;

  // start latches only while still zero; end follows every axis event
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
    end else begin
      if (ctl.wr_x) begin
        end_x_r <= val;
        if (start_x_r == '0) start_x_r <= val;
      end
      if (ctl.wr_y) begin
        end_y_r <= val;
        if (start_y_r == '0) start_y_r <= val;
      end
    end
  end

  assign start_x = start_x_r;
  assign start_y = start_y_r;
  assign end_x   = end_x_r;
  assign end_y   = end_y_r;

endmodule

`default_nettype wire

/* hdl/tsgd_scale_unit.sv */
// Shared scaling unit: floor(v * num / den) saturated to 16 bits, a
// multiply step then a 32-step restoring divider. Depends on tsgd_pkg.
`default_nettype none

module tsgd_scale_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [tsgd_pkg::CoordW-1:0]   v,
  input  wire logic [tsgd_pkg::CoordW-1:0]   num,
  input  wire logic [tsgd_pkg::CoordW-1:0]   den,
  output tsgd_pkg::scl_stat_t                stat,
  output logic      [tsgd_pkg::CoordW-1:0]   result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [15:0] v_r, num_r, den_r;
  logic [31:0] acc_r, acc_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] res_r, res_nxt;
  logic [16:0] shifted;
  logic        ge;
  logic [16:0] diff;

  // one restoring step; a zero divisor gives all ones, hence saturation
  assign shifted = {rem_r, acc_r[31]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  // sequencing of multiply and divide steps
  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) st_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt = {16'd0, v_r} * {16'd0, num_r};
        rem_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? diff[15:0] : shifted[15:0];
        acc_nxt = {acc_r[30:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          st_nxt   = S_IDLE;
          done_nxt = 1'b1;
          res_nxt  = (acc_nxt[31:16] != '0) ? 16'hFFFF : acc_nxt[15:0];
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    if (st_r == S_IDLE && start) begin
      v_r   <= v;
      num_r <= num;
      den_r <= den;
    end
  end

  assign stat.busy = (st_r != S_IDLE);
  assign stat.done = done_r;
  assign result    = res_r;

endmodule

`default_nettype wire

/* hdl/touch_swipe_gesture_decoder_unit.sv */
// Touch swipe gesture decoder. Axis events (type 3, code 0 or 1) update the
// tracked start/end coordinates and are taken while the decoder is idle. A key
// release (type 1, value 0) yields one item: scaled end position and swipe
// direction, then tracking clears. A release runs four scalings (end and start
// of X and Y) one after another through one shared multiply plus 32-step serial
// divider, and in_tready stays low until the result is loaded into the output
// register; that divider sets the rate. The result sits in an output register,
// so the next event is taken while it waits. Depends on tsgd_pkg, tsgd_track and
// tsgd_scale_unit.
`default_nettype none

module touch_swipe_gesture_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input events
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // event_type[15:0], event_code[31:16], event_value[47:32]
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // pos_x[15:0], pos_y[31:16], swipe_dir[34:32], zero pad
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [tsgd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;

  // configuration registers
  logic [15:0] screen_w_r, screen_h_r, touch_w_r, touch_h_r, min_sw_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[tsgd_pkg::CfgAddrW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= tsgd_pkg::RST_SCREEN_W;
      screen_h_r <= tsgd_pkg::RST_SCREEN_H;
      touch_w_r  <= tsgd_pkg::RST_TOUCH_W;
      touch_h_r  <= tsgd_pkg::RST_TOUCH_H;
      min_sw_r   <= tsgd_pkg::RST_MIN_SW;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tsgd_pkg::REG_SCREEN_W: screen_w_r <= cfg_pwdata[15:0];
        tsgd_pkg::REG_SCREEN_H: screen_h_r <= cfg_pwdata[15:0];
        tsgd_pkg::REG_TOUCH_W:  touch_w_r  <= cfg_pwdata[15:0];
        tsgd_pkg::REG_TOUCH_H:  touch_h_r  <= cfg_pwdata[15:0];
        tsgd_pkg::REG_MIN_SW:   min_sw_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      tsgd_pkg::REG_SCREEN_W: cfg_prdata = {16'd0, screen_w_r};
      tsgd_pkg::REG_SCREEN_H: cfg_prdata = {16'd0, screen_h_r};
      tsgd_pkg::REG_TOUCH_W:  cfg_prdata = {16'd0, touch_w_r};
      tsgd_pkg::REG_TOUCH_H:  cfg_prdata = {16'd0, touch_h_r};
      tsgd_pkg::REG_MIN_SW:   cfg_prdata = {16'd0, min_sw_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // event decode
  logic [15:0] ev_type, ev_code, ev_val;
  logic        in_acc, is_abs_x, is_abs_y, is_release;

  assign ev_type    = in_tdata[15:0];
  assign ev_code    = in_tdata[31:16];
  assign ev_val     = in_tdata[47:32];
  assign in_acc     = in_tvalid & in_tready;
  assign is_abs_x   = (ev_type == tsgd_pkg::EVT_ABS) && (ev_code == tsgd_pkg::AXIS_X);
  assign is_abs_y   = (ev_type == tsgd_pkg::EVT_ABS) && (ev_code == tsgd_pkg::AXIS_Y);
  assign is_release = (ev_type == tsgd_pkg::EVT_KEY) && (ev_val == '0);

  // sequencer state
  logic [1:0]  state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;      // bit 0: axis (0 X, 1 Y); bit 1: 0 end, 1 start
  logic        go_r, go_nxt;
  logic        out_load;
  logic        out_valid_r, out_valid_nxt;

  tsgd_pkg::trk_ctl_t  trk_ctl;
  tsgd_pkg::scl_stat_t scl_stat;
  logic [15:0] start_x, start_y, end_x, end_y;
  logic [15:0] scl_v, scl_num, scl_den, scl_res;
  logic        scl_start;

  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  assign trk_ctl.wr_x = in_acc & is_abs_x;
  assign trk_ctl.wr_y = in_acc & is_abs_y;
  assign trk_ctl.clr  = out_load;

  tsgd_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (trk_ctl),
    .val     (ev_val),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y)
  );

  // operand selection for the shared scaling unit
  always_comb begin
    unique case (op_r)
      2'd0:    scl_v = end_x;
      2'd1:    scl_v = end_y;
      2'd2:    scl_v = start_x;
      default: scl_v = start_y;
    endcase
  end
  assign scl_num   = op_r[0] ? screen_h_r : screen_w_r;
  assign scl_den   = op_r[0] ? touch_h_r  : touch_w_r;
  assign scl_start = (state_r == ST_SCALE) && go_r;

  tsgd_scale_unit u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scl_start),
    .v      (scl_v),
    .num    (scl_num),
    .den    (scl_den),
    .stat   (scl_stat),
    .result (scl_res)
  );

  // scaled coordinates
  logic [15:0] sc_ex_r, sc_ey_r, sc_sx_r, sc_sy_r;

  always_ff @(posedge clk) begin
    if (scl_stat.done) begin
      unique case (op_r)
        2'd0:    sc_ex_r <= scl_res;
        2'd1:    sc_ey_r <= scl_res;
        2'd2:    sc_sx_r <= scl_res;
        default: sc_sy_r <= scl_res;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    go_nxt    = go_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_release) begin
          state_nxt = ST_SCALE;
          op_nxt    = '0;
          go_nxt    = 1'b1;
        end
      end
      ST_SCALE: begin
        if (scl_start) go_nxt = 1'b0;
        if (scl_stat.done) begin
          if (op_r == 2'd3) begin
            state_nxt = ST_OUT;
          end else begin
            op_nxt = op_r + 2'd1;
            go_nxt = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= '0;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      go_r    <= go_nxt;
    end
  end

  // swipe direction from scaled start and end
  logic [15:0]  adx, ady;
  logic [2:0]   dir;

  assign adx = (sc_ex_r >= sc_sx_r) ? (sc_ex_r - sc_sx_r) : (sc_sx_r - sc_ex_r);
  assign ady = (sc_ey_r >= sc_sy_r) ? (sc_ey_r - sc_sy_r) : (sc_sy_r - sc_ey_r);

  always_comb begin
    priority if (adx < min_sw_r && ady < min_sw_r) begin
      dir = tsgd_pkg::DIR_NONE;
    end else if (adx > ady) begin
      dir = (sc_ex_r > sc_sx_r) ? tsgd_pkg::DIR_RIGHT : tsgd_pkg::DIR_LEFT;
    end else begin
      dir = (sc_ey_r > sc_sy_r) ? tsgd_pkg::DIR_DOWN : tsgd_pkg::DIR_UP;
    end
  end

  // output register
  logic [39:0] out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= {5'd0, dir, sc_ey_r, sc_ex_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_done_in_scale: assert property (@(posedge clk) disable iff (!rst_n)
    scl_stat.done |-> state_r == ST_SCALE)
    else $error("scaling result arrived outside the scaling phase");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    scl_start |-> !scl_stat.busy)
    else $error("scaling unit started while busy");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34:32] == tsgd_pkg::DIR_NONE  ||
                    out_tdata[34:32] == tsgd_pkg::DIR_LEFT  ||
                    out_tdata[34:32] == tsgd_pkg::DIR_RIGHT ||
                    out_tdata[34:32] == tsgd_pkg::DIR_UP    ||
                    out_tdata[34:32] == tsgd_pkg::DIR_DOWN))
    else $error("swipe direction code out of range");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0))
    else $error("tracking not cleared after a result");

endmodule

`default_nettype wire
